FILE: rtl/asc_pkg.sv
// Shared constants and types for the step counter datapath.
// No dependencies; every other file refers to this package by scoped names.
package asc_pkg;

  localparam int AXIS_W    = 16;  // raw accelerometer sample width
  localparam int SQ_W      = 32;  // sum of three squares
  localparam int MAG_W     = 16;  // vector magnitude and filtered magnitude
  localparam int TIME_W    = 32;  // millisecond timestamp
  localparam int CFG_W     = 16;  // widest configuration register
  localparam int CFG_IDX_W = 1;

  // every serial unit runs sixteen steps: one bit of a square, two bits of the
  // radicand, or one quotient bit of the average
  localparam int ITER_N = 16;
  localparam int ITER_W = $clog2(ITER_N);

  localparam int WINDOW_LENGTH = 5;

  localparam logic [CFG_W-1:0] STEP_THRESHOLD_RST = 16'd9355;
  localparam logic [CFG_W-1:0] COOLDOWN_RST       = 16'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_THRESHOLD = 1'b0,
    CFG_COOLDOWN       = 1'b1
  } cfg_idx_e;

endpackage

FILE: rtl/asc_sqsum.sv
// Bit-serial sum of squares of three signed axis samples, one multiplier bit per cycle.
// Depends on asc_pkg.
module asc_sqsum (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [asc_pkg::AXIS_W-1:0]   ax_i,
  input  logic signed [asc_pkg::AXIS_W-1:0]   ay_i,
  input  logic signed [asc_pkg::AXIS_W-1:0]   az_i,
  output logic                                done_o,
  output logic        [asc_pkg::SQ_W-1:0]     sum_o
);

  localparam int AW = asc_pkg::AXIS_W;
  localparam int HW = AW + 2;  // upper product half holds up to three addends

  function automatic logic [AW-1:0] abs_val(input logic signed [AW-1:0] v);
    abs_val = v[AW-1] ? (~v + AW'(1)) : v;
  endfunction

  logic [AW-1:0]          mcand_q [3];
  logic [AW-1:0]          mplier_q [3];
  logic [HW-1:0]          hi_q;
  logic [AW-1:0]          lo_q;
  logic [asc_pkg::ITER_W-1:0] cnt_q;
  logic                   busy_q;
  logic                   done_q;
  logic [HW:0]            addend;
  logic [HW:0]            acc;

  always_comb begin
    addend = '0;
    for (int i = 0; i < 3; i++) begin
      if (mplier_q[i][0]) begin
        addend = addend + {3'b000, mcand_q[i]};
      end
    end
    acc = {1'b0, hi_q} + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == asc_pkg::ITER_W'(asc_pkg::ITER_N - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == asc_pkg::ITER_W'(asc_pkg::ITER_N - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // shift the partial product right, retiring one product bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q[0]  <= abs_val(ax_i);
      mcand_q[1]  <= abs_val(ay_i);
      mcand_q[2]  <= abs_val(az_i);
      mplier_q[0] <= abs_val(ax_i);
      mplier_q[1] <= abs_val(ay_i);
      mplier_q[2] <= abs_val(az_i);
      hi_q        <= '0;
      lo_q        <= '0;
    end else if (busy_q) begin
      hi_q <= acc[HW:1];
      lo_q <= {acc[0], lo_q[AW-1:1]};
      for (int i = 0; i < 3; i++) begin
        mplier_q[i] <= {1'b0, mplier_q[i][AW-1:1]};
      end
    end
  end

  assign done_o = done_q;
  assign sum_o  = {hi_q[AW-1:0], lo_q};

endmodule

FILE: rtl/asc_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on asc_pkg.
module asc_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [asc_pkg::SQ_W-1:0]     radicand_i,
  output logic                         done_o,
  output logic [asc_pkg::MAG_W-1:0]    root_o
);

  localparam int NW = asc_pkg::SQ_W;
  localparam int RW = asc_pkg::MAG_W;
  localparam int MW = RW + 1;  // remainder never exceeds twice the root

  logic [NW-1:0]  n_q;
  logic [MW-1:0]  rem_q;
  logic [RW-1:0]  root_q;
  logic [asc_pkg::ITER_W-1:0] cnt_q;
  logic           busy_q;
  logic           done_q;
  logic [MW+1:0]  rem_sh;
  logic [MW+1:0]  trial;
  logic [MW+1:0]  diff;
  logic           ge;

  always_comb begin
    rem_sh = {rem_q, n_q[NW-1:NW-2]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == asc_pkg::ITER_W'(asc_pkg::ITER_N - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == asc_pkg::ITER_W'(asc_pkg::ITER_N - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= {n_q[NW-3:0], 2'b00};
      rem_q  <= ge ? diff[MW-1:0] : rem_sh[MW-1:0];
      root_q <= {root_q[RW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: rtl/asc_window.sv
// Ring window of magnitudes with its running sum and a bit-serial divide by the length.
// Depends on asc_pkg.
module asc_window #(
  parameter int WINDOW_LENGTH = asc_pkg::WINDOW_LENGTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [asc_pkg::MAG_W-1:0]    mag_i,
  output logic                         done_o,
  output logic [asc_pkg::MAG_W-1:0]    filt_o
);

  localparam int MW    = asc_pkg::MAG_W;
  localparam int IW    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int TW    = $clog2(WINDOW_LENGTH + 1);  // sum bits above the magnitude width
  localparam int SUM_W = MW + TW;
  localparam int RW    = TW + 1;                     // partial remainder below twice the length

  logic [MW-1:0]            mem [WINDOW_LENGTH];
  logic [WINDOW_LENGTH-1:0] valid_q;
  logic [MW-1:0]            rd_q;
  logic [IW-1:0]            slot_q;
  logic [SUM_W-1:0]         sum_q;
  logic [SUM_W-1:0]         sum_new;
  logic [MW-1:0]            oldest;
  logic [RW-1:0]            rem_q;
  logic [RW-1:0]            rem_sh;
  logic                     q_bit;
  logic [MW-1:0]            quo_q;
  logic [asc_pkg::ITER_W-1:0] cnt_q;
  logic                     busy_q;
  logic                     done_q;

  // entries not yet written since reset read as zero
  assign oldest  = valid_q[slot_q] ? rd_q : '0;
  assign sum_new = sum_q - SUM_W'(oldest) + SUM_W'(mag_i);

  always_comb begin
    rem_sh = {rem_q[RW-2:0], quo_q[MW-1]};
    q_bit  = (rem_sh >= RW'(WINDOW_LENGTH));
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mem[slot_q] <= mag_i;
    end
    rd_q <= mem[slot_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      slot_q  <= '0;
      sum_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == asc_pkg::ITER_W'(asc_pkg::ITER_N - 1));
      if (start_i) begin
        valid_q[slot_q] <= 1'b1;
        slot_q <= (slot_q == IW'(WINDOW_LENGTH - 1)) ? '0 : slot_q + 1'b1;
        sum_q  <= sum_new;
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == asc_pkg::ITER_W'(asc_pkg::ITER_N - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // the sum is below length * 2^16, so its upper part already sits under the
  // divisor and only sixteen quotient bits remain to be found
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RW'(sum_new[SUM_W-1:MW]);
      quo_q <= sum_new[MW-1:0];
    end else if (busy_q) begin
      rem_q <= q_bit ? (rem_sh - RW'(WINDOW_LENGTH)) : rem_sh;
      quo_q <= {quo_q[MW-2:0], q_bit};
    end
  end

  assign done_o = done_q;
  assign filt_o = quo_q;

endmodule

FILE: rtl/accel_step_counter.sv
// accel_step_counter: pedometer over a moving average of acceleration magnitude.
// A sample passes through the sum of squares, the root, the window update and the
// divide into the output stage; a new sample is taken only after the last result is
// loaded there, since the three serial units run one after another on one sample.
// Reset (async, active low) clears the window, its sum, the tally, the last step
// time and the output stage, and loads the default threshold and cooldown.
module accel_step_counter #(
  parameter int WINDOW_LENGTH = asc_pkg::WINDOW_LENGTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [asc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [asc_pkg::CFG_W-1:0]            cfg_wdata_i,
  // sample channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [asc_pkg::AXIS_W-1:0]    accel_x_i,
  input  logic signed [asc_pkg::AXIS_W-1:0]    accel_y_i,
  input  logic signed [asc_pkg::AXIS_W-1:0]    accel_z_i,
  input  logic [asc_pkg::TIME_W-1:0]           time_ms_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [asc_pkg::MAG_W-1:0]            filtered_magnitude_o,
  output logic [asc_pkg::MAG_W-1:0]            step_total_o,
  output logic                                 step_seen_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_HOLD
  } state_e;

  localparam logic [asc_pkg::MAG_W-1:0] TALLY_MAX = '1;

  state_e                        state_q;
  logic [asc_pkg::CFG_W-1:0]     thr_q;
  logic [asc_pkg::CFG_W-1:0]     cool_q;
  logic [asc_pkg::TIME_W-1:0]    time_q;
  logic [asc_pkg::TIME_W-1:0]    last_q;
  logic [asc_pkg::MAG_W-1:0]     tally_q;
  logic [asc_pkg::MAG_W-1:0]     filt_q;
  logic                          seen_q;
  logic                          out_valid_q;

  logic                          in_fire;
  logic                          sq_done;
  logic [asc_pkg::SQ_W-1:0]      sq_sum;
  logic                          rt_done;
  logic [asc_pkg::MAG_W-1:0]     mag;
  logic                          win_done;
  logic [asc_pkg::MAG_W-1:0]     filt;
  logic [asc_pkg::TIME_W-1:0]    elapsed;
  logic                          step_hit;
  logic                          out_free;
  logic                          out_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // The first unit starts on an accepted sample, each other on the done pulse of the
  // one before it; each keeps its result in its own registers until started again.
  asc_sqsum u_sqsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .ax_i    (accel_x_i),
    .ay_i    (accel_y_i),
    .az_i    (accel_z_i),
    .done_o  (sq_done),
    .sum_o   (sq_sum)
  );

  asc_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_done),
    .radicand_i (sq_sum),
    .done_o     (rt_done),
    .root_o     (mag)
  );

  asc_window #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rt_done),
    .mag_i   (mag),
    .done_o  (win_done),
    .filt_o  (filt)
  );

  // Step decision: average strictly above threshold and strictly more than the
  // cooldown elapsed; the time difference wraps modulo 2^32.
  assign elapsed  = time_q - last_q;
  assign step_hit = (filt > thr_q) &&
                    (elapsed > asc_pkg::TIME_W'(cool_q));
  assign out_free = !out_valid_q || out_ready_i;
  // load the output stage once the sample is finished and the stage is free
  assign out_load = (state_q == S_HOLD || (state_q == S_BUSY && win_done)) && out_free;

  // Configuration registers; both indexes are defined, nothing to ignore.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= asc_pkg::STEP_THRESHOLD_RST;
      cool_q <= asc_pkg::COOLDOWN_RST;
    end else if (cfg_we_i) begin
      unique case (asc_pkg::cfg_idx_e'(cfg_idx_i))
        asc_pkg::CFG_STEP_THRESHOLD: thr_q  <= cfg_wdata_i;
        asc_pkg::CFG_COOLDOWN:       cool_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer, step state and output stage. The result waits in the output
  // register; a sample finishing while the previous result is still unread
  // holds in S_HOLD until the output stage frees up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_q      <= '0;
      last_q      <= '0;
      tally_q     <= '0;
      filt_q      <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            time_q  <= time_ms_i;
            state_q <= S_BUSY;
          end
        end
        S_BUSY, S_HOLD: begin
          if (out_load) begin
            filt_q      <= filt;
            seen_q      <= step_hit;
            if (step_hit) begin
              last_q <= time_q;
              if (tally_q != TALLY_MAX) begin
                tally_q <= tally_q + 1'b1;
              end
            end
            state_q <= S_IDLE;
          end else if (win_done) begin
            state_q <= S_HOLD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o          = out_valid_q;
  assign filtered_magnitude_o = filt_q;
  assign step_total_o         = tally_q;
  assign step_seen_o          = seen_q;

endmodule

FILE: rtl/asc_checker.sv
// Port-level checks for accel_step_counter, attached to it by the bind below.
// Depends on asc_pkg and accel_step_counter.
module asc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [asc_pkg::MAG_W-1:0]     filtered_magnitude_o,
  input logic [asc_pkg::MAG_W-1:0]     step_total_o,
  input logic                          step_seen_o
);

  logic                        out_fire;
  logic [asc_pkg::MAG_W-1:0]   prev_total_q;
  logic [asc_pkg::MAG_W-1:0]   exp_total;

  assign out_fire  = out_valid_o && out_ready_i;
  assign exp_total = !step_seen_o                ? prev_total_q :
                     (prev_total_q == '1)        ? prev_total_q :
                                                   prev_total_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_total_q <= '0;
    end else if (out_fire) begin
      prev_total_q <= step_total_o;
    end
  end

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_magnitude_o) &&
      $stable(step_total_o) && $stable(step_seen_o))
    else $error("result changed while stalled");

  // one sample at a time: accepting a sample closes the input
  a_in_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input stayed open after a transaction");

  // a new result only appears while a sample was in flight
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared with no sample in flight");

  // the tally advances by exactly the step flag, saturating
  a_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> step_total_o == exp_total)
    else $error("step total does not follow step flag");

endmodule

bind accel_step_counter asc_checker u_asc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_ready_o           (in_ready_o),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .filtered_magnitude_o (filtered_magnitude_o),
  .step_total_o         (step_total_o),
  .step_seen_o          (step_seen_o)
);

FILE: tb/testbench.sv
// Self-checking testbench for accel_step_counter: directed table, then random phases.
// Depends on asc_pkg for widths and register indexes; predicts every result in place.
module testbench;

  localparam int WIN_LEN          = asc_pkg::WINDOW_LENGTH;
  localparam int DIR_ROWS         = 18;
  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 230;
  localparam int SETTLE_CYCLES    = 60;
  localparam int HOLD_OFF_CYCLES  = 600;     // long enough to back the block up
  localparam int WATCHDOG_TIME    = 2000000;

  typedef struct packed {
    logic signed [asc_pkg::AXIS_W-1:0] x;
    logic signed [asc_pkg::AXIS_W-1:0] y;
    logic signed [asc_pkg::AXIS_W-1:0] z;
    logic [asc_pkg::TIME_W-1:0]        t;
  } sample_t;

  typedef struct packed {
    logic [asc_pkg::MAG_W-1:0] filt;
    logic [asc_pkg::MAG_W-1:0] total;
    logic                      seen;
  } step_report_t;

  // one row of the directed table; lit marks a row whose result is typed in
  typedef struct packed {
    sample_t      smp;
    logic         lit;
    step_report_t want;
  } dir_row_t;

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              cfg_we_i    = 1'b0;
  logic [asc_pkg::CFG_IDX_W-1:0]     cfg_idx_i   = asc_pkg::CFG_STEP_THRESHOLD;
  logic [asc_pkg::CFG_W-1:0]         cfg_wdata_i = '0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_ready_o;
  logic signed [asc_pkg::AXIS_W-1:0] accel_x_i   = '0;
  logic signed [asc_pkg::AXIS_W-1:0] accel_y_i   = '0;
  logic signed [asc_pkg::AXIS_W-1:0] accel_z_i   = '0;
  logic [asc_pkg::TIME_W-1:0]        time_ms_i   = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b1;
  logic [asc_pkg::MAG_W-1:0]         filtered_magnitude_o;
  logic [asc_pkg::MAG_W-1:0]         step_total_o;
  logic                              step_seen_o;

  accel_step_counter u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .accel_x_i            (accel_x_i),
    .accel_y_i            (accel_y_i),
    .accel_z_i            (accel_z_i),
    .time_ms_i            (time_ms_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .filtered_magnitude_o (filtered_magnitude_o),
    .step_total_o         (step_total_o),
    .step_seen_o          (step_seen_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Pedometer predictor: its own copy of the window, tally and registers
  // ---------------------------------------------------------------------------
  logic [asc_pkg::MAG_W-1:0]  win_mag [WIN_LEN] = '{default: '0};
  int                         win_ptr        = 0;
  int                         win_sum        = 0;
  logic [asc_pkg::MAG_W-1:0]  steps_counted  = '0;
  logic [asc_pkg::TIME_W-1:0] last_stride_ms = '0;
  logic [asc_pkg::CFG_W-1:0]  thr_cfg        = asc_pkg::STEP_THRESHOLD_RST;
  logic [asc_pkg::CFG_W-1:0]  cool_cfg       = asc_pkg::COOLDOWN_RST;

  step_report_t reports_due[$];  // results still owed by the block, oldest first
  int           mismatches   = 0;

  // directed rows may replace the predicted result by a typed-in one
  bit           quote_row     = 1'b0;
  step_report_t quoted_report = '0;

  // idling controls shared by the sample driver and the result sink
  bit calm         = 1'b0;
  bit hold_off_req = 1'b0;
  int stall_left   = 0;

  function automatic step_report_t pedometer_predict(sample_t s);
    int                           ax, ay, az;
    longint unsigned              sq, trial;
    logic [asc_pkg::MAG_W-1:0]    root;
    logic [asc_pkg::TIME_W-1:0]   elapsed;
    step_report_t                 r;
    ax = int'(s.x);
    ay = int'(s.y);
    az = int'(s.z);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    if (az < 0) az = -az;
    sq = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
    // settle the magnitude one bit at a time from the top
    root = '0;
    for (int b = asc_pkg::MAG_W - 1; b >= 0; b--) begin
      trial = longint'(root | (16'd1 << b));
      if (trial * trial <= sq) root = root | (16'd1 << b);
    end
    // replace the oldest window entry and keep the sum exact
    win_sum          = win_sum - int'(win_mag[win_ptr]) + int'(root);
    win_mag[win_ptr] = root;
    win_ptr          = (win_ptr + 1) % WIN_LEN;
    r.filt           = 16'(win_sum / WIN_LEN);
    elapsed          = s.t - last_stride_ms;  // wraps modulo 2^32
    r.seen           = (r.filt > thr_cfg) && (elapsed > 32'(cool_cfg));
    if (r.seen) begin
      if (steps_counted != '1) steps_counted++;  // tally saturates
      last_stride_ms = s.t;
    end
    r.total = steps_counted;
    return r;
  endfunction

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on every accepted sample, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    sample_t      taken;
    step_report_t due, got;
    if (in_valid_i && in_ready_o) begin
      taken.x = accel_x_i;
      taken.y = accel_y_i;
      taken.z = accel_z_i;
      taken.t = time_ms_i;
      due     = pedometer_predict(taken);
      reports_due.push_back(quote_row ? quoted_report : due);
    end
    if (out_valid_o && out_ready_i) begin
      got.filt  = filtered_magnitude_o;
      got.total = step_total_o;
      got.seen  = step_seen_o;
      if (reports_due.size() == 0) begin
        $error("result transaction with no sample outstanding");
        mismatches++;
      end else begin
        due = reports_due.pop_front();
        check_field("filtered_magnitude", due.filt, got.filt);
        check_field("step_total", due.total, got.total);
        check_field("step_seen", due.seen, got.seen);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : result_sink
    if (hold_off_req) begin
      stall_left   = HOLD_OFF_CYCLES;
      hold_off_req = 1'b0;
    end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 8);
    end
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // end the run if the block stops answering
  initial begin : watchdog
    #(WATCHDOG_TIME);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sample driver helpers; every call starts at a falling edge
  // ---------------------------------------------------------------------------

  // Offer one sample, maybe after an idle burst, and hold it until accepted.
  task automatic send_sample(sample_t s);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i  <= s.x;
    accel_y_i  <= s.y;
    accel_z_i  <= s.z;
    time_ms_i  <= s.t;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(asc_pkg::cfg_idx_e idx, logic [asc_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      asc_pkg::CFG_STEP_THRESHOLD: thr_cfg  = val;
      asc_pkg::CFG_COOLDOWN:       cool_cfg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [asc_pkg::AXIS_W-1:0] axis_near(int amp);
    return 16'(int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  function automatic logic signed [asc_pkg::AXIS_W-1:0] axis_corner();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'shFFFF;
      3:       return 16'sh0001;
      default: return 16'sh0000;
    endcase
  endfunction

  // Directed table. Warm-up from an empty window, all-axis extremes, the
  // cooldown boundary hit exactly and one past it, the window drained back to
  // zero, and a timestamp wrap both inside and outside the cooldown.
  dir_row_t dir_rows [DIR_ROWS];

  initial begin : stimulus
    sample_t                   smp;
    int                        amp;
    int                        mode;
    logic [asc_pkg::TIME_W-1:0] clock_ms;
    logic [asc_pkg::CFG_W-1:0]  thr, cool;

    dir_rows = '{
      // after reset: empty window, nothing to count
      '{'{16'sh0000, 16'sh0000, 16'sh0000, 32'd0}, 1'b1, '{16'd0, 16'd0, 1'b0}},
      // most negative on every axis: magnitude 56755, one fifth of it averaged
      '{'{16'sh8000, 16'sh8000, 16'sh8000, 32'd1000}, 1'b1, '{16'd11351, 16'd1, 1'b1}},
      '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd1200}, 1'b0, '0},
      '{'{16'sh7FFF, 16'sh8000, 16'sh0000, 32'd1300}, 1'b0, '0},
      '{'{16'sh0000, 16'sh0000, 16'sh8000, 32'd1301}, 1'b0, '0},
      '{'{16'shFFFF, 16'sh0001, 16'shFFFF, 32'd1302}, 1'b0, '0},
      '{'{16'sh0000, 16'sh0000, 16'sh0000, 32'd5000}, 1'b0, '0},
      '{'{16'sh0000, 16'sh0000, 16'sh0000, 32'd5001}, 1'b0, '0},
      '{'{16'sh0000, 16'sh0000, 16'sh0000, 32'd5002}, 1'b0, '0},
      '{'{16'sh0000, 16'sh0000, 16'sh0000, 32'd5003}, 1'b0, '0},
      '{'{16'sh0000, 16'sh0000, 16'sh0000, 32'd5004}, 1'b0, '0},
      '{'{16'sh8000, 16'sh0000, 16'sh0000, 32'hFFFF_FF00}, 1'b0, '0},
      '{'{16'sh7FFF, 16'sh0000, 16'sh0000, 32'hFFFF_FFFF}, 1'b0, '0},
      '{'{16'sh8000, 16'sh7FFF, 16'sh0000, 32'h0000_0010}, 1'b0, '0},
      '{'{16'sh0000, 16'sh8000, 16'sh7FFF, 32'h0000_0030}, 1'b0, '0},
      '{'{16'sh7FFF, 16'sh8000, 16'sh8000, 32'h0000_0031}, 1'b0, '0},
      '{'{16'sh1234, 16'shA988, 16'sh012C, 32'h8000_0000}, 1'b0, '0},
      '{'{16'sh8000, 16'sh8000, 16'sh8000, 32'h7FFF_FFFF}, 1'b0, '0}
    };

    // hold reset, then release it away from the rising edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows run on the reset values of both registers
    for (int i = 0; i < DIR_ROWS; i++) begin
      @(negedge clk_i);
      quote_row     = dir_rows[i].lit;
      quoted_report = dir_rows[i].want;
      send_sample(dir_rows[i].smp);
    end
    quote_row = 1'b0;

    clock_ms = 32'd100000;
    amp      = 8000;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      case (ph)
        0: begin thr = 16'd0;     cool = 16'd0;     end
        1: begin thr = 16'hFFFF;  cool = 16'hFFFF;  end
        2: begin thr = asc_pkg::STEP_THRESHOLD_RST; cool = asc_pkg::COOLDOWN_RST; end
        4: begin thr = 16'd1;     cool = 16'hFFFF;  end
        5: begin thr = 16'd20000; cool = 16'd50;    end
        7: begin thr = 16'd12000; cool = 16'd300;   end
        default: begin
          thr  = 16'($urandom());
          cool = 16'($urandom_range(0, 1000));
        end
      endcase
      write_cfg(asc_pkg::CFG_STEP_THRESHOLD, thr);
      write_cfg(asc_pkg::CFG_COOLDOWN, cool);

      // back the block up once; run the last phase with no idling at all
      if (ph == 2) hold_off_req = 1'b1;
      if (ph == 5) clock_ms = 32'hFFFF_F000;
      calm = (ph == PHASES - 1);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        @(negedge clk_i);
        // walking bursts: now and then the amplitude jumps low, near the threshold or high
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 2))
            0:       amp = $urandom_range(0, 3000);
            1:       amp = int'(thr_cfg) * int'($urandom_range(60, 140)) / 100;
            default: amp = $urandom_range(20000, 32767);
          endcase
          if (amp > 32767) amp = 32767;
        end
        mode = $urandom_range(0, 19);
        if (mode < 14) begin
          smp.x = axis_near(amp);
          smp.y = axis_near(amp);
          smp.z = axis_near(amp);
        end else if (mode < 17) begin
          smp.x = 16'($urandom());
          smp.y = 16'($urandom());
          smp.z = 16'($urandom());
        end else if (mode == 17) begin
          smp.x = axis_corner();
          smp.y = axis_corner();
          smp.z = axis_corner();
        end else begin
          smp.x = axis_near(4);
          smp.y = axis_near(4);
          smp.z = axis_near(4);
        end
        // mostly steady time, with cooldown boundaries and wild jumps mixed in
        case ($urandom_range(0, 19))
          0:       clock_ms = last_stride_ms + 32'(cool_cfg) + 32'($urandom_range(0, 1));
          1:       clock_ms = $urandom();
          2, 3:    clock_ms = clock_ms + $urandom_range(0, 70000);
          default: clock_ms = clock_ms + $urandom_range(0, 400);
        endcase
        smp.t = clock_ms;
        send_sample(smp);
      end
    end

    wait_quiet();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/asc_pkg.sv
rtl/asc_sqsum.sv
rtl/asc_isqrt.sv
rtl/asc_window.sv
rtl/accel_step_counter.sv
rtl/asc_checker.sv
tb/testbench.sv
